// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define FBD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fbd assertion failed");

// The condition must never be true outside reset.
`define FBD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fbd forbidden condition seen");

`else

`define FBD_ASSERT(lbl, clk, rst_n, prop)
`define FBD_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: hw/rtl/fbd_pkg.sv
package fbd_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int BTN_NUM         = 4;
    localparam int REP_NUM         = 2;

    // Button positions.
    localparam int BTN_UP     = 0;
    localparam int BTN_DOWN   = 1;
    localparam int BTN_SELECT = 2;
    localparam int BTN_BACK   = 3;

    localparam logic [15:0] DEBOUNCE_RST     = 16'd30;
    localparam logic [15:0] REPEAT_DELAY_RST = 16'd500;
    localparam logic [15:0] REPEAT_PERIOD_RST = 16'd150;
    localparam logic [15:0] RESET_HOLD_RST   = 16'd3000;
    localparam logic [3:0]  BUTTON_MASK_RST  = 4'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE      = 3'd0,
        CFG_REPEAT_DELAY  = 3'd1,
        CFG_REPEAT_PERIOD = 3'd2,
        CFG_RESET_HOLD    = 3'd3,
        CFG_BUTTON_MASK   = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_UP_PRESS    = 3'd1,
        EV_DOWN_PRESS  = 3'd2,
        EV_SEL_PRESS   = 3'd3,
        EV_BACK_PRESS  = 3'd4,
        EV_UP_REPEAT   = 3'd5,
        EV_DOWN_REPEAT = 3'd6,
        EV_RESET       = 3'd7
    } event_code_t;

    typedef struct packed {
        logic raw_up;
        logic raw_down;
        logic raw_select;
        logic raw_back;
    } fbd_in_t;

    typedef struct packed {
        logic [2:0] event_code;
        logic       combo_held;
    } fbd_out_t;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] repeat_delay_ticks;
        logic [15:0] repeat_period_ticks;
        logic [15:0] reset_hold_ticks;
    } fbd_cfg_t;

    // Per-button view of the state after this tick's debounce step.
    typedef struct packed {
        logic pressed;
        logic pending;
        logic repeat_due;
        logic hold_met;
    } fbd_btn_stat_t;

    // Consumption of a button's pending press or repeat by the event picker.
    typedef struct packed {
        logic pending_clr;
        logic repeat_clr;
    } fbd_btn_ctl_t;

endpackage

// File: hw/rtl/fbd_button.sv
`include "assert_macros.svh"

module fbd_button #(
    parameter int COUNT_WIDTH = fbd_pkg::COUNT_WIDTH_DEF,
    parameter bit HAS_REPEAT  = 1'b1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  raw,
    input  fbd_pkg::fbd_cfg_t     cfg,
    input  fbd_pkg::fbd_btn_ctl_t ctl,
    output fbd_pkg::fbd_btn_stat_t stat
);
    import fbd_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic                   stable_reg, stable_next;
    logic                   last_raw_reg, last_raw_next;
    logic [COUNT_WIDTH-1:0] steady_reg, steady_next;
    logic [COUNT_WIDTH-1:0] held_reg, held_next;
    logic                   pending_reg, pending_next;
    logic [COUNT_WIDTH-1:0] rep_cur;
    logic [COUNT_WIDTH-1:0] rep_step;
    logic                   accept_lvl;
    logic                   delay_met;
    logic                   period_met;

    always_comb
    begin
        held_next     = held_reg;
        rep_step      = rep_cur;
        last_raw_next = last_raw_reg;
        stable_next   = stable_reg;
        pending_next  = pending_reg;

        if (!stable_reg)
        begin
            held_next = (held_reg == '1) ? held_reg : held_reg + 1'b1;
            rep_step  = (rep_cur == '1) ? rep_cur : rep_cur + 1'b1;
        end

        if (raw != last_raw_reg)
        begin
            last_raw_next = raw;
            steady_next   = '0;
        end
        else
        begin
            steady_next = (steady_reg == '1) ? steady_reg : steady_reg + 1'b1;
        end

        accept_lvl = (raw != stable_reg) &&
                     (CMP_W'(steady_next) >= CMP_W'(cfg.debounce_ticks));
        if (accept_lvl)
        begin
            stable_next  = raw;
            held_next    = '0;
            rep_step     = '0;
            pending_next = ~raw;
        end

        delay_met  = CMP_W'(held_next) >= CMP_W'(cfg.repeat_delay_ticks);
        period_met = CMP_W'(rep_step) >= CMP_W'(cfg.repeat_period_ticks);

        stat.pressed    = ~stable_next;
        stat.pending    = pending_next;
        stat.repeat_due = HAS_REPEAT && ~stable_next && delay_met && period_met;
        stat.hold_met   = CMP_W'(held_next) >= CMP_W'(cfg.reset_hold_ticks);
    end

    generate
        if (HAS_REPEAT)
        begin : g_rep
            logic [COUNT_WIDTH-1:0] repeat_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    repeat_reg <= '0;
                end
                else if (en)
                begin
                    repeat_reg <= ctl.repeat_clr ? '0 : rep_step;
                end
            end

            assign rep_cur = repeat_reg;
        end
        else
        begin : g_norep
            assign rep_cur = '0;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg   <= 1'b1;
            last_raw_reg <= 1'b1;
            steady_reg   <= '0;
            held_reg     <= '0;
            pending_reg  <= 1'b0;
        end
        else if (en)
        begin
            stable_reg   <= stable_next;
            last_raw_reg <= last_raw_next;
            steady_reg   <= steady_next;
            held_reg     <= held_next;
            pending_reg  <= pending_next & ~ctl.pending_clr;
        end
    end

    // A pending press only exists while the button is stably pressed.
    `FBD_ASSERT(a_pend_pressed, clk, rst_n, pending_reg |-> !stable_reg)
    // The picker never consumes a press that is not there.
    `FBD_NEVER(a_clr_idle, clk, rst_n, en && ctl.pending_clr && !pending_next)
    // A level change is always followed by a cleared steady count.
    `FBD_ASSERT(a_steady_clr, clk, rst_n,
        (en && raw != last_raw_reg) |=> (steady_reg == '0))

endmodule

// File: hw/rtl/fbd_event.sv
`include "assert_macros.svh"

module fbd_event (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  fbd_pkg::fbd_btn_stat_t stat [fbd_pkg::BTN_NUM],
    output fbd_pkg::fbd_btn_ctl_t  ctl  [fbd_pkg::BTN_NUM],
    output fbd_pkg::fbd_out_t      result
);
    import fbd_pkg::*;

    logic        fired_reg, fired_next;
    logic        reported_reg, reported_next;
    logic        combo;
    event_code_t code;

    always_comb
    begin
        for (int i = 0; i < BTN_NUM; i++)
        begin
            ctl[i] = '0;
        end
        code  = EV_NONE;
        combo = stat[BTN_SELECT].pressed && stat[BTN_BACK].pressed;

        // Both held counts past the limit is the same as their minimum past it.
        if (combo)
        begin
            fired_next    = fired_reg ||
                            (stat[BTN_SELECT].hold_met && stat[BTN_BACK].hold_met);
            reported_next = reported_reg;
        end
        else
        begin
            fired_next    = 1'b0;
            reported_next = 1'b0;
        end

        if (fired_next && !reported_next)
        begin
            reported_next = 1'b1;
            code          = EV_RESET;
        end
        else if (stat[BTN_UP].pending)
        begin
            ctl[BTN_UP].pending_clr = 1'b1;
            code = EV_UP_PRESS;
        end
        else if (stat[BTN_DOWN].pending)
        begin
            ctl[BTN_DOWN].pending_clr = 1'b1;
            code = EV_DOWN_PRESS;
        end
        else if (stat[BTN_SELECT].pending)
        begin
            ctl[BTN_SELECT].pending_clr = 1'b1;
            code = EV_SEL_PRESS;
        end
        else if (stat[BTN_BACK].pending)
        begin
            ctl[BTN_BACK].pending_clr = 1'b1;
            code = EV_BACK_PRESS;
        end
        else if (stat[BTN_UP].repeat_due)
        begin
            ctl[BTN_UP].repeat_clr = 1'b1;
            code = EV_UP_REPEAT;
        end
        else if (stat[BTN_DOWN].repeat_due)
        begin
            ctl[BTN_DOWN].repeat_clr = 1'b1;
            code = EV_DOWN_REPEAT;
        end

        result.event_code = code;
        result.combo_held = combo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fired_reg    <= 1'b0;
            reported_reg <= 1'b0;
        end
        else if (en)
        begin
            fired_reg    <= fired_next;
            reported_reg <= reported_next;
        end
    end

    // At most one press or repeat is consumed per tick.
    `FBD_ASSERT(a_one_clr, clk, rst_n,
        $onehot0({ctl[0], ctl[1], ctl[2], ctl[3]}))
    // A reset request consumes nothing else.
    `FBD_NEVER(a_reset_alone, clk, rst_n,
        (code == EV_RESET) && ({ctl[0], ctl[1], ctl[2], ctl[3]} != '0))
    // The request is only ever reported after the hold was reached.
    `FBD_ASSERT(a_rep_fired, clk, rst_n, reported_reg |-> fired_reg)

endmodule

// File: hw/rtl/four_button_debounce_events.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid / in_ready         in_data (fbd_in_t), one tick
// out       output     out_valid / out_ready       out_data (fbd_out_t)
// cfg       input      cfg_we, cfg_index           cfg_wdata, no wait state
//
// One tick is taken per cycle while the result register is not stalled; its
// result passes from the input register into the result register.
// The tick sits in an input register, the debounce and event update is
// combinational from there into the result register.
// A stalled result register stops the input register, then in_ready drops.
// Reset releases all buttons and loads the configuration defaults.
`include "assert_macros.svh"

module four_button_debounce_events #(
    parameter int COUNT_WIDTH = fbd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  fbd_pkg::fbd_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output fbd_pkg::fbd_out_t                 out_data,
    input  logic                              cfg_we,
    input  logic [fbd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import fbd_pkg::*;

    fbd_cfg_t      cfg_reg;
    logic [3:0]    mask_reg;
    logic          s1_valid_reg;
    fbd_in_t       s1_data_reg;
    logic          out_valid_reg;
    fbd_out_t      out_data_reg;
    logic          advance;
    logic [BTN_NUM-1:0] raw_in;
    logic [BTN_NUM-1:0] raw_eff;
    fbd_btn_stat_t stat [BTN_NUM];
    fbd_btn_ctl_t  ctl  [BTN_NUM];
    fbd_out_t      result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks      <= DEBOUNCE_RST;
            cfg_reg.repeat_delay_ticks  <= REPEAT_DELAY_RST;
            cfg_reg.repeat_period_ticks <= REPEAT_PERIOD_RST;
            cfg_reg.reset_hold_ticks    <= RESET_HOLD_RST;
            mask_reg                    <= BUTTON_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:      cfg_reg.debounce_ticks      <= cfg_wdata;
                CFG_REPEAT_DELAY:  cfg_reg.repeat_delay_ticks  <= cfg_wdata;
                CFG_REPEAT_PERIOD: cfg_reg.repeat_period_ticks <= cfg_wdata;
                CFG_RESET_HOLD:    cfg_reg.reset_hold_ticks    <= cfg_wdata;
                CFG_BUTTON_MASK:   mask_reg                    <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign raw_in[BTN_UP]     = s1_data_reg.raw_up;
    assign raw_in[BTN_DOWN]   = s1_data_reg.raw_down;
    assign raw_in[BTN_SELECT] = s1_data_reg.raw_select;
    assign raw_in[BTN_BACK]   = s1_data_reg.raw_back;
    // An unassigned button reads as released.
    assign raw_eff = raw_in | ~mask_reg;

    generate
        for (genvar i = 0; i < BTN_NUM; i++)
        begin : g_btn
            fbd_button #(
                .COUNT_WIDTH (COUNT_WIDTH),
                .HAS_REPEAT  (i < REP_NUM)
            ) u_button (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (advance),
                .raw   (raw_eff[i]),
                .cfg   (cfg_reg),
                .ctl   (ctl[i]),
                .stat  (stat[i])
            );
        end
    endgenerate

    fbd_event u_event (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .stat   (stat),
        .ctl    (ctl),
        .result (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Every tick that leaves the input register lands in the result register.
    `FBD_ASSERT(a_adv_out, clk, rst_n, advance |=> out_valid_reg)
    // A reset request is only reported while the combination is held.
    `FBD_NEVER(a_reset_combo, clk, rst_n,
        out_valid_reg && (out_data_reg.event_code == EV_RESET) && !out_data_reg.combo_held)
    // An empty input register always takes a new tick.
    `FBD_ASSERT(a_empty_ready, clk, rst_n, !s1_valid_reg |-> in_ready)

endmodule

// File: bench/tb_four_button_debounce_events.sv
module tb_four_button_debounce_events;
    import fbd_pkg::*;

    localparam int CNT_W       = COUNT_WIDTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int N_RANDOM    = 450;

    typedef struct {
        logic [15:0] deb;
        logic [15:0] rep_delay;
        logic [15:0] rep_period;
        logic [15:0] combo_hold;
        logic [3:0]  enables;
    } setting_t;

    typedef struct {
        int       setting;
        fbd_in_t  tick;
        bit       pinned;
        fbd_out_t result;
    } row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    fbd_in_t  in_data;
    logic     out_valid;
    logic     out_ready = 1'b0;
    fbd_out_t out_data;
    logic     cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Optional fixed expectation that travels with the tick.
    bit       pin_flag;
    fbd_out_t pin_value;

    int send_idle_pct = 33;
    int recv_idle_pct = 86;
    int quiet_cycles  = 0;
    bit fail_seen     = 1'b0;

    fbd_out_t awaited_events [$];
    fbd_out_t want;

    // Shadow configuration.
    logic [15:0] cfg_debounce;
    logic [15:0] cfg_repeat_delay;
    logic [15:0] cfg_repeat_period;
    logic [15:0] cfg_reset_hold;
    logic [3:0]  mask_q;

    // Shadow button state.
    logic [BTN_NUM-1:0] settled;
    logic [BTN_NUM-1:0] prev_raw;
    logic [BTN_NUM-1:0] press_waiting;
    logic [CNT_W-1:0]   quiet_ticks  [BTN_NUM];
    logic [CNT_W-1:0]   hold_ticks   [BTN_NUM];
    logic [CNT_W-1:0]   since_repeat [BTN_NUM];
    logic               combo_fired;
    logic               combo_told;

    event_code_t press_code  [BTN_NUM] = '{EV_UP_PRESS, EV_DOWN_PRESS, EV_SEL_PRESS,
                                           EV_BACK_PRESS};
    event_code_t repeat_code [REP_NUM] = '{EV_UP_REPEAT, EV_DOWN_REPEAT};

    setting_t presets [5] = '{
        '{DEBOUNCE_RST, REPEAT_DELAY_RST, REPEAT_PERIOD_RST, RESET_HOLD_RST, BUTTON_MASK_RST},
        '{16'd0, 16'd2, 16'd1, 16'd0, 4'b1111},
        '{16'd2, 16'd0, 16'd0, 16'd3, 4'b1010},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1111},
        '{16'd0, 16'd0, 16'd0, 16'd0, 4'b1111}
    };

    // Bit order of a tick is up, down, select, back; a zero is a pressed button.
    row_t plan [26] = '{
        '{0, 4'b0000, 1'b1, {EV_NONE, 1'b0}},
        '{0, 4'b0000, 1'b1, {EV_NONE, 1'b0}},
        '{1, 4'b0111, 1'b1, {EV_UP_PRESS, 1'b0}},
        '{1, 4'b0111, 1'b1, {EV_NONE, 1'b0}},
        '{1, 4'b0111, 1'b0, 4'b0000},
        '{1, 4'b0111, 1'b0, 4'b0000},
        '{1, 4'b1111, 1'b0, 4'b0000},
        '{1, 4'b1011, 1'b1, {EV_DOWN_PRESS, 1'b0}},
        '{1, 4'b1011, 1'b0, 4'b0000},
        '{1, 4'b1011, 1'b0, 4'b0000},
        '{1, 4'b0000, 1'b0, 4'b0000},
        '{1, 4'b0001, 1'b0, 4'b0000},
        '{1, 4'b1111, 1'b0, 4'b0000},
        '{2, 4'b0000, 1'b0, 4'b0000},
        '{2, 4'b0000, 1'b0, 4'b0000},
        '{2, 4'b0000, 1'b0, 4'b0000},
        '{2, 4'b1010, 1'b0, 4'b0000},
        '{2, 4'b0101, 1'b0, 4'b0000},
        '{2, 4'b1111, 1'b0, 4'b0000},
        '{2, 4'b1111, 1'b0, 4'b0000},
        '{3, 4'b0000, 1'b1, {EV_NONE, 1'b0}},
        '{3, 4'b0000, 1'b1, {EV_NONE, 1'b0}},
        '{4, 4'b0000, 1'b1, {EV_RESET, 1'b1}},
        '{4, 4'b0000, 1'b1, {EV_UP_PRESS, 1'b1}},
        '{4, 4'b0000, 1'b0, 4'b0000},
        '{4, 4'b1111, 1'b0, 4'b0000}
    };

    four_button_debounce_events dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void clear_buttons();
        cfg_debounce      = DEBOUNCE_RST;
        cfg_repeat_delay  = REPEAT_DELAY_RST;
        cfg_repeat_period = REPEAT_PERIOD_RST;
        cfg_reset_hold    = RESET_HOLD_RST;
        mask_q            = BUTTON_MASK_RST;
        settled           = '1;
        prev_raw          = '1;
        press_waiting     = '0;
        combo_fired       = 1'b0;
        combo_told        = 1'b0;
        for (int i = 0; i < BTN_NUM; i++)
        begin
            quiet_ticks[i]  = '0;
            hold_ticks[i]   = '0;
            since_repeat[i] = '0;
        end
    endfunction

    // One tick of the button unit: debounce, combo, then the event.
    function automatic fbd_out_t advance_buttons(fbd_in_t tick);
        logic [BTN_NUM-1:0] raw;
        logic               combo;
        logic [CNT_W-1:0]   hold;
        event_code_t        code;
        fbd_out_t           res;
        raw[BTN_UP]     = tick.raw_up;
        raw[BTN_DOWN]   = tick.raw_down;
        raw[BTN_SELECT] = tick.raw_select;
        raw[BTN_BACK]   = tick.raw_back;
        for (int i = 0; i < BTN_NUM; i++)
        begin
            // An unassigned button reads as released.
            if (!mask_q[i])
                raw[i] = 1'b1;
            if (!settled[i])
            begin
                hold_ticks[i] = bump(hold_ticks[i]);
                if (i < REP_NUM)
                    since_repeat[i] = bump(since_repeat[i]);
            end
            if (raw[i] != prev_raw[i])
            begin
                prev_raw[i]    = raw[i];
                quiet_ticks[i] = '0;
            end
            else
                quiet_ticks[i] = bump(quiet_ticks[i]);
            if (raw[i] != settled[i] && quiet_ticks[i] >= cfg_debounce)
            begin
                settled[i]      = raw[i];
                hold_ticks[i]   = '0;
                since_repeat[i] = '0;
                press_waiting[i] = !raw[i];
            end
        end

        combo = !settled[BTN_SELECT] && !settled[BTN_BACK];
        if (combo)
        begin
            hold = (hold_ticks[BTN_SELECT] < hold_ticks[BTN_BACK]) ?
                   hold_ticks[BTN_SELECT] : hold_ticks[BTN_BACK];
            if (!combo_fired && hold >= cfg_reset_hold)
                combo_fired = 1'b1;
        end
        else
        begin
            combo_fired = 1'b0;
            combo_told  = 1'b0;
        end

        code = EV_NONE;
        if (combo_fired && !combo_told)
        begin
            combo_told = 1'b1;
            code       = EV_RESET;
        end
        else
        begin
            for (int i = 0; i < BTN_NUM; i++)
                if (code == EV_NONE && press_waiting[i])
                begin
                    press_waiting[i] = 1'b0;
                    code             = press_code[i];
                end
            for (int i = 0; i < REP_NUM; i++)
                if (code == EV_NONE && !settled[i] && hold_ticks[i] >= cfg_repeat_delay &&
                    since_repeat[i] >= cfg_repeat_period)
                begin
                    since_repeat[i] = '0;
                    code            = repeat_code[i];
                end
        end
        res.event_code = code;
        res.combo_held = combo;
        return res;
    endfunction

    function automatic logic [15:0] pick_count(int hi);
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 16'd0;
        if (roll < 15)
            return 16'hFFFF;
        return 16'($urandom_range(hi));
    endfunction

    function automatic setting_t random_setting();
        setting_t s;
        s.deb        = pick_count(4);
        s.rep_delay  = pick_count(12);
        s.rep_period = pick_count(6);
        s.combo_hold = pick_count(25);
        s.enables    = ($urandom_range(99) < 70) ? 4'hF : 4'($urandom_range(15));
        return s;
    endfunction

    // Receiver side: random back-pressure.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Predict on every input transfer, check on every output transfer, and
    // watch for a stalled pipe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                want = advance_buttons(in_data);
                if (pin_flag)
                    want = pin_value;
                awaited_events.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                if (awaited_events.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got %0d/%0d", $time,
                             out_data.event_code, out_data.combo_held);
                    fail_seen = 1'b1;
                end
                else
                begin
                    want = awaited_events.pop_front();
                    if (out_data.event_code !== want.event_code)
                    begin
                        $display("%0t: event_code expected %0d, got %0d", $time,
                                 want.event_code, out_data.event_code);
                        fail_seen = 1'b1;
                    end
                    if (out_data.combo_held !== want.combo_held)
                    begin
                        $display("%0t: combo_held expected %0d, got %0d", $time,
                                 want.combo_held, out_data.combo_held);
                        fail_seen = 1'b1;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_tick(fbd_in_t tick, bit pinned, fbd_out_t result);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_data   <= tick;
        pin_flag  <= pinned;
        pin_value <= result;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Hold off the sender until every predicted result has come out.
    task automatic settle_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic apply_setting(setting_t s);
        settle_outputs();
        put_reg(CFG_DEBOUNCE, s.deb);
        put_reg(CFG_REPEAT_DELAY, s.rep_delay);
        put_reg(CFG_REPEAT_PERIOD, s.rep_period);
        put_reg(CFG_RESET_HOLD, s.combo_hold);
        put_reg(CFG_BUTTON_MASK, {12'($urandom), s.enables});
        // A write past the last register must change nothing.
        put_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, int'(CFG_BUTTON_MASK) + 1)),
                CFG_DATA_W'($urandom));
        cfg_we            <= 1'b0;
        cfg_debounce      = s.deb;
        cfg_repeat_delay  = s.rep_delay;
        cfg_repeat_period = s.rep_period;
        cfg_reset_hold    = s.combo_hold;
        mask_q            = s.enables;
    endtask

    // Mostly held button patterns, with one-tick glitches mixed in.
    task automatic random_phase(int n_ticks);
        setting_t s;
        fbd_in_t  held;
        int       left;
        int       seg;
        int       run;
        int       span;
        left = n_ticks;
        while (left > 0)
        begin
            s = random_setting();
            apply_setting(s);
            seg  = $urandom_range(90, 40);
            span = (s.deb > 6) ? 6 : int'(s.deb);
            while (seg > 0 && left > 0)
            begin
                if ($urandom_range(99) < 30)
                    held = {2'($urandom_range(3)), 2'b00};
                else
                    held = 4'($urandom_range(15));
                run = $urandom_range(span + 20, 1);
                while (run > 0 && seg > 0 && left > 0)
                begin
                    if ($urandom_range(99) < 8)
                        send_tick(4'($urandom_range(15)), 1'b0, '0);
                    else
                        send_tick(held, 1'b0, '0);
                    run--;
                    seg--;
                    left--;
                end
            end
        end
    endtask

    initial
    begin
        int cur;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '1;
        pin_flag  <= 1'b0;
        pin_value <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_DEBOUNCE;
        cfg_wdata <= '0;
        clear_buttons();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur = 0;
        foreach (plan[k])
        begin
            if (plan[k].setting != cur)
            begin
                apply_setting(presets[plan[k].setting]);
                cur = plan[k].setting;
            end
            send_tick(plan[k].tick, plan[k].pinned, plan[k].result);
        end

        random_phase(N_RANDOM);
        send_idle_pct = 86;
        recv_idle_pct = 33;
        random_phase(N_RANDOM);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(N_RANDOM);

        settle_outputs();
        repeat (4) @(posedge clk);
        if (awaited_events.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, awaited_events.size());
            fail_seen = 1'b1;
        end
        if (!fail_seen)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
